/* rtl/rfop_pkg.sv */
// Package for the ring sector outline point generator.
// Holds shared widths, constants, the arctangent table and the controller/datapath command struct.
package rfop_pkg;

    localparam int MaxSegmentsDefault = 30;
    localparam int AngleW   = 20;
    localparam int LenW     = 24;
    localparam int SegW     = 6;
    localparam int CfgDataW = 24;
    localparam int CfgIdxW  = 3;
    localparam int CordicSteps = 16;
    localparam int StepW    = 4;

    localparam logic [CfgIdxW-1:0] RegAngleBegin = 3'd0;
    localparam logic [CfgIdxW-1:0] RegAngleEnd   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegFrameWidth = 3'd2;
    localparam logic [CfgIdxW-1:0] RegSegCount   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegRadiusSel  = 3'd4;

    localparam logic signed [AngleW+1:0] FullTurn    = 22'sd92160;
    localparam logic signed [AngleW+1:0] HalfTurn    = 22'sd46080;
    localparam logic signed [AngleW+1:0] QuarterTurn = 22'sd23040;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    // Arctangent of 2^-i in 2^-16 degree units.
    function automatic logic signed [29:0] atan_lut(input logic [StepW-1:0] i);
        logic signed [29:0] v;
        case (i)
            4'd0:  v = 30'sd2949120;
            4'd1:  v = 30'sd1740967;
            4'd2:  v = 30'sd919879;
            4'd3:  v = 30'sd466945;
            4'd4:  v = 30'sd234379;
            4'd5:  v = 30'sd117304;
            4'd6:  v = 30'sd58666;
            4'd7:  v = 30'sd29335;
            4'd8:  v = 30'sd14668;
            4'd9:  v = 30'sd7334;
            4'd10: v = 30'sd3667;
            4'd11: v = 30'sd1833;
            4'd12: v = 30'sd917;
            4'd13: v = 30'sd458;
            4'd14: v = 30'sd229;
            default: v = 30'sd115;
        endcase
        return v;
    endfunction

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;        // capture dimension and run setup
        logic div_start;   // start angle division for current point
        logic div_step;    // one restoring division step
        logic ang_prep;    // form and reduce the angle
        logic cordic_init;
        logic cordic_step;
        logic mul_x;       // radius times cosine
        logic mul_y;       // radius times sine
        logic emit;        // load output register
        logic inner;
        logic last;
    } rfop_cmd_t;

endpackage

/* rtl/rfop_datapath.sv */
// Datapath: angle interpolation divider, CORDIC, radius multiply, saturation, output register.
// Uses rfop_pkg.
module rfop_datapath
    import rfop_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rfop_cmd_t                cmd,
    input  logic [StepW-1:0]         step,
    input  logic [SegW-1:0]          idx,
    input  logic [SegW-1:0]          steps,
    input  logic signed [AngleW-1:0] angle_begin,
    input  logic signed [AngleW-1:0] angle_end,
    input  logic [LenW-1:0]          frame_width,
    input  logic                     radius_from_width,
    input  logic [LenW-1:0]          box_width,
    input  logic [LenW-1:0]          box_height,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic signed [LenW-1:0]   point_x,
    output logic signed [LenW-1:0]   point_y,
    output logic                     on_inner_ring,
    output logic                     last_point
);
    localparam int ProdW = 27;  // |diff*idx| < 2^27
    localparam int RadW  = 26;

    logic [LenW-1:0] dim_reg;
    logic [ProdW-1:0] rem_reg, quo_reg;
    logic [ProdW-1:0] rem_next, quo_next;
    logic neg_reg;
    logic signed [AngleW+1:0] ang_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [29:0] z_reg;
    logic flip_reg;
    logic signed [LenW:0] cx_reg;
    logic signed [LenW-1:0] px_reg, py_reg;
    logic inner_reg, last_reg, valid_reg;

    logic signed [AngleW:0] diff;
    logic signed [AngleW+SegW+1:0] prod;
    logic [ProdW:0] trial;
    logic signed [AngleW+1:0] a_sum, a_mod, a_fold;
    logic signed [AngleW+1:0] ang_fold;
    logic fold_flip;
    logic signed [RadW-1:0] radius;
    logic signed [33:0] trig, xs, ys;
    logic signed [RadW+34:0] mprod;
    logic signed [LenW:0] coord;

    assign diff = AngleW'(0) + (AngleW+1)'(angle_end) - (AngleW+1)'(angle_begin);
    assign prod = (AngleW+SegW+2)'(diff) * $signed({2'b0, idx});
    assign trial = {rem_reg, quo_reg[ProdW-1]} - {{(ProdW-SegW+1){1'b0}}, steps};

    // Restoring division of |diff*idx| by steps, one quotient bit a cycle.
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (!trial[ProdW]) begin
            rem_next = trial[ProdW-1:0];
            quo_next = {quo_reg[ProdW-2:0], 1'b1};
        end else begin
            rem_next = {rem_reg[ProdW-2:0], quo_reg[ProdW-1]};
            quo_next = {quo_reg[ProdW-2:0], 1'b0};
        end
    end

    // Angle reduction into [-180, 180) degrees. The angle lies between the two
    // register angles, so it is offset by six turns to make it non-negative and
    // then reduced by binary weighted turn subtraction.
    always_comb begin
        logic signed [AngleW+1:0] base;
        base = (AngleW+2)'(angle_begin) + (FullTurn <<< 2) + (FullTurn <<< 1);
        a_sum = neg_reg ? base - $signed({1'b0, quo_reg[AngleW:0]})
                        : base + $signed({1'b0, quo_reg[AngleW:0]});
        a_mod = a_sum;
        if (a_mod >= (FullTurn <<< 3)) a_mod = a_mod - (FullTurn <<< 3);
        if (a_mod >= (FullTurn <<< 2)) a_mod = a_mod - (FullTurn <<< 2);
        if (a_mod >= (FullTurn <<< 1)) a_mod = a_mod - (FullTurn <<< 1);
        if (a_mod >= FullTurn) a_mod = a_mod - FullTurn;
        if (a_mod >= HalfTurn) a_mod = a_mod - FullTurn;
        a_fold = a_mod;
    end

    // Fold the reduced angle into [-90, 90] degrees; folding flips the cosine.
    always_comb begin
        if (ang_reg > QuarterTurn) begin
            ang_fold  = HalfTurn - ang_reg;
            fold_flip = 1'b1;
        end else if (ang_reg < -QuarterTurn) begin
            ang_fold  = -HalfTurn - ang_reg;
            fold_flip = 1'b1;
        end else begin
            ang_fold  = ang_reg;
            fold_flip = 1'b0;
        end
    end

    assign xs = x_reg >>> step;
    assign ys = y_reg >>> step;
    assign radius = inner_reg ? $signed({2'b0, dim_reg}) - $signed({1'b0, frame_width, 1'b0})
                              : $signed({2'b0, dim_reg});
    assign trig = cmd.mul_x ? (flip_reg ? -x_reg : x_reg) : y_reg;
    assign mprod = radius * trig + (RadW+35)'(64'sd1 <<< 30);
    always_comb begin
        logic signed [RadW+34:0] sh;
        sh = mprod >>> 31;
        if (sh > 8388607) coord = 25'sd8388607;
        else if (sh < -8388608) coord = -25'sd8388608;
        else coord = sh[LenW:0];
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) dim_reg <= radius_from_width ? box_width : box_height;
        if (cmd.div_start) begin
            neg_reg <= prod < 0;
            quo_reg <= ProdW'(prod < 0 ? -prod : prod);
            rem_reg <= '0;
            inner_reg <= cmd.inner;
            last_reg <= cmd.last;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.ang_prep) ang_reg <= a_fold;
        if (cmd.cordic_init) begin
            x_reg <= CordicGain;
            y_reg <= '0;
            z_reg <= 30'(ang_fold) <<< 8;
            flip_reg <= fold_flip;
        end else if (cmd.cordic_step) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_lut(step);
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_lut(step);
            end
        end
        if (cmd.mul_x) cx_reg <= coord;
        if (cmd.emit) begin
            px_reg <= cx_reg[LenW-1:0];
            py_reg <= coord[LenW-1:0];
        end
    end

    // Output valid with its own handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    logic inner_o_reg, last_o_reg;
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            inner_o_reg <= inner_reg;
            last_o_reg  <= last_reg;
        end
    end

    assign out_valid     = valid_reg;
    assign point_x       = px_reg;
    assign point_y       = py_reg;
    assign on_inner_ring = inner_o_reg;
    assign last_point    = last_o_reg;

    // A new item is loaded only when the output register is free or being taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!valid_reg || out_ready))
        else $error("output overwritten");

    // A waiting item stays valid and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> (out_valid && $stable(point_x) && $stable(point_y)
            && $stable(on_inner_ring) && $stable(last_point)))
        else $error("waiting output item changed");
endmodule

/* rtl/rfop_ctrl.sv */
// Controller: sequences points of one run through divide, CORDIC, multiply and emit.
// Uses rfop_pkg.
module rfop_ctrl
    import rfop_pkg::*;
#(
    parameter int MAX_SEGMENTS = MaxSegmentsDefault
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [SegW-1:0] segment_count,
    input  logic                 out_valid,
    input  logic                 out_ready,
    output rfop_cmd_t            cmd,
    output logic [StepW-1:0]     step,
    output logic [SegW-1:0]      idx,
    output logic [SegW-1:0]      steps
);
    typedef enum logic [2:0] {S_IDLE, S_DIV, S_ANG, S_CINIT, S_CORD, S_MULX, S_MULY} state_t;
    state_t state_reg;
    logic [4:0] cnt_reg;
    logic [SegW:0] k_reg;
    logic [SegW-1:0] n_reg, steps_reg;

    logic signed [SegW-1:0] seg;
    logic [SegW:0] total;
    logic inner;
    assign seg   = (segment_count > SegW'(MAX_SEGMENTS)) ? SegW'(MAX_SEGMENTS) : segment_count;
    assign total = {n_reg, 1'b0};
    assign inner = k_reg >= {1'b0, n_reg};
    assign idx   = inner ? SegW'(total - 1'b1 - k_reg) : k_reg[SegW-1:0];
    assign steps = steps_reg;
    assign step  = cnt_reg[StepW-1:0];
    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd = '0;
        cmd.inner = inner;
        cmd.last  = (k_reg == total - 1'b1);
        case (state_reg)
            S_IDLE:  cmd.load = in_valid;
            S_DIV:   cmd.div_step = 1'b1;
            S_ANG:   cmd.ang_prep = 1'b1;
            S_CINIT: cmd.cordic_init = 1'b1;
            S_CORD:  cmd.cordic_step = 1'b1;
            S_MULX:  cmd.mul_x = 1'b1;
            S_MULY:  begin
                cmd.mul_y = 1'b1;
                cmd.emit  = !out_valid || out_ready;
            end
            default: ;
        endcase
        if (state_reg == S_IDLE && in_valid && !segment_count[SegW-1]) cmd.div_start = 1'b0;
    end

    // Start of each point: the first cycle in S_DIV, in which the division setup is applied.
    logic start_pt;
    assign start_pt = (state_reg == S_DIV) && (cnt_reg == 5'd31);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            k_reg <= '0;
            n_reg <= '0;
            steps_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: if (in_valid && !segment_count[SegW-1]) begin
                    n_reg <= SegW'(seg + 2);
                    steps_reg <= SegW'(seg + 1);
                    k_reg <= '0;
                    cnt_reg <= 5'd31;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (cnt_reg == 5'd31) cnt_reg <= '0;
                    else if (cnt_reg == 5'd26) state_reg <= S_ANG;
                    else cnt_reg <= cnt_reg + 1'b1;
                end
                S_ANG:   state_reg <= S_CINIT;
                S_CINIT: begin cnt_reg <= '0; state_reg <= S_CORD; end
                S_CORD: begin
                    if (cnt_reg == 5'(CordicSteps-1)) state_reg <= S_MULX;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_MULX: state_reg <= S_MULY;
                S_MULY: if (!out_valid || out_ready) begin
                    if (k_reg == total - 1'b1) begin
                        state_reg <= S_IDLE;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                        cnt_reg <= 5'd31;
                        state_reg <= S_DIV;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // The CORDIC count never runs past the last step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CORD) |-> (cnt_reg < 5'(CordicSteps)))
        else $error("cordic count overrun");

    // Every point that starts lies inside the run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        start_pt |-> (k_reg < total))
        else $error("point index overrun");
endmodule

/* rtl/ring_frame_outline_points_top.sv */
// Ring sector outline point generator, top level.
// Each point passes setup, divide, angle, CORDIC and multiply; requests wait for idle.
// One request takes 2*(segment_count+2) points, segment_count capped at MAX_SEGMENTS.
// The iterative divider and the CORDIC set the per-point time.
// Reset (aresetn, synchronous, low) restores register defaults and empties the output.
// Uses rfop_pkg, rfop_ctrl, rfop_datapath.
module ring_frame_outline_points_top
    import rfop_pkg::*;
#(
    parameter int MAX_SEGMENTS = MaxSegmentsDefault
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CfgIdxW-1:0]     cfg_index,
    input  logic [CfgDataW-1:0]    cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [LenW-1:0]        s_box_width,
    input  logic [LenW-1:0]        s_box_height,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [LenW-1:0] m_point_x,
    output logic signed [LenW-1:0] m_point_y,
    output logic                   m_on_inner_ring,
    output logic                   m_last_point
);
    logic signed [AngleW-1:0] angle_begin_reg, angle_end_reg;
    logic [LenW-1:0] frame_width_reg;
    logic signed [SegW-1:0] seg_count_reg;
    logic radius_sel_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_begin_reg <= '0;
            angle_end_reg   <= 20'sd92160;
            frame_width_reg <= 24'd2560;
            seg_count_reg   <= 6'sd8;
            radius_sel_reg  <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                RegAngleBegin: angle_begin_reg <= cfg_data[AngleW-1:0];
                RegAngleEnd:   angle_end_reg   <= cfg_data[AngleW-1:0];
                RegFrameWidth: frame_width_reg <= cfg_data;
                RegSegCount:   seg_count_reg   <= cfg_data[SegW-1:0];
                RegRadiusSel:  radius_sel_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    rfop_cmd_t cmd, cmd_dp;
    logic [StepW-1:0] step;
    logic [SegW-1:0] idx, steps;
    logic div_start_reg;

    rfop_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready),
        .segment_count(seg_count_reg),
        .out_valid(m_valid), .out_ready(m_ready),
        .cmd, .step, .idx, .steps
    );

    // Division setup is issued on the first cycle of each point's divide phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) div_start_reg <= 1'b0;
        else div_start_reg <= (s_valid && s_ready && !seg_count_reg[SegW-1]) ||
                              (cmd.emit && !cmd.last);
    end
    always_comb begin
        cmd_dp = cmd;
        cmd_dp.div_start = div_start_reg;
        cmd_dp.div_step  = cmd.div_step && !div_start_reg;
    end

    rfop_datapath u_dp (
        .aclk, .aresetn, .cmd(cmd_dp), .step, .idx, .steps,
        .angle_begin(angle_begin_reg), .angle_end(angle_end_reg),
        .frame_width(frame_width_reg), .radius_from_width(radius_sel_reg),
        .box_width(s_box_width), .box_height(s_box_height),
        .out_ready(m_ready), .out_valid(m_valid),
        .point_x(m_point_x), .point_y(m_point_y),
        .on_inner_ring(m_on_inner_ring), .last_point(m_last_point)
    );
endmodule
